// ----- rtl/qtl_pkg.sv -----
// Shared types and constants for the quoted token lexer.
package qtl_pkg;

	// Character codes used by the lexer rules
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChHash   = 8'h23;
	localparam logic [7:0] ChNl     = 8'h0A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] ChColon  = 8'h3A;
	localparam logic [7:0] ChEquals = 8'h3D;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChDash   = 8'h2D;
	localparam logic [7:0] ChUscore = 8'h5F;

	// Bit positions of the flags on the result tuser
	localparam int UserHasChar  = 0;
	localparam int UserTokEnd   = 1;
	localparam int UserTokDisc  = 2;
	localparam int UserLineOk   = 3;
	localparam int UserW        = 4;

	// One lexer result
	typedef struct packed {
		logic       has_char;
		logic [7:0] out_char;
		logic       token_end;
		logic       token_discard;
		logic       line_done;
		logic       line_ok;
	} result_t;

endpackage

// ----- rtl/qtl_step.sv -----
// Lexer mode and line error registers with the per-character step logic.
module qtl_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,   // commit this character's step
	input  logic [7:0]          ch,
	input  logic                line_end,
	output qtl_pkg::result_t    res
);

	typedef enum logic [2:0] {
		MODE_BLANK   = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_QUOTED  = 3'd2,
		MODE_ESCAPED = 3'd3,
		MODE_COMMENT = 3'd4
	} mode_t;

	mode_t mode_q, mode_nxt, mode_new;
	logic  err_q, err_nxt, err_new;
	logic [7:0] c;
	logic  is_word, is_blank;

	// Classify the character; a terminator acts as a newline
	always_comb begin
		c = line_end ? qtl_pkg::ChNl : ch;
		is_word = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == qtl_pkg::ChDot ||
			c == qtl_pkg::ChColon || c == qtl_pkg::ChEquals ||
			c == qtl_pkg::ChSlash || c == qtl_pkg::ChDash ||
			c == qtl_pkg::ChUscore;
		is_blank = c == qtl_pkg::ChSpace || c == qtl_pkg::ChTab ||
			c == qtl_pkg::ChCr || c == qtl_pkg::ChNl;
	end

	// Advance the lexer by one character
	always_comb begin
		mode_new = mode_q;
		err_new  = err_q;
		res      = '0;
		if (!err_q) begin
			case (mode_q)
				MODE_BLANK: begin
					if (is_word) begin
						mode_new     = MODE_WORD;
						res.has_char = 1'b1;
						res.out_char = c;
					end else if (c == qtl_pkg::ChQuote) begin
						mode_new = MODE_QUOTED;
					end else if (is_blank) begin
						mode_new = MODE_BLANK;
					end else if (c == qtl_pkg::ChHash) begin
						mode_new = MODE_COMMENT;
					end else begin
						err_new = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_word) begin
						res.has_char = 1'b1;
						res.out_char = c;
					end else if (is_blank) begin
						res.token_end = 1'b1;
						mode_new      = MODE_BLANK;
					end else if (c == qtl_pkg::ChHash) begin
						res.token_discard = 1'b1;
						mode_new          = MODE_COMMENT;
					end else begin
						err_new = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (c == qtl_pkg::ChQuote) begin
						res.token_end = 1'b1;
						mode_new      = MODE_BLANK;
					end else if (c == qtl_pkg::ChBslash) begin
						mode_new = MODE_ESCAPED;
					end else begin
						res.has_char = 1'b1;
						res.out_char = c;
					end
				end
				MODE_ESCAPED: begin
					res.has_char = 1'b1;
					res.out_char = c;
					mode_new     = MODE_QUOTED;
				end
				MODE_COMMENT: begin
					mode_new = MODE_COMMENT;
				end
				default: begin
					mode_new = MODE_BLANK;
				end
			endcase
		end
		// Report the line and start the next one clean
		mode_nxt = mode_new;
		err_nxt  = err_new;
		if (line_end) begin
			res.line_done = 1'b1;
			res.line_ok   = !err_new &&
				(mode_new == MODE_BLANK || mode_new == MODE_COMMENT);
			mode_nxt      = MODE_BLANK;
			err_nxt       = 1'b0;
		end
	end

	// Hold mode and sticky error between characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BLANK;
			err_q  <= 1'b0;
		end else if (step_en) begin
			mode_q <= mode_nxt;
			err_q  <= err_nxt;
		end
	end

endmodule

// ----- rtl/quoted_token_lexer_unit.sv -----
// Quoted token lexer: the input transaction is registered in stage 1 and the lexer result in stage 2.
// Throughput one character per clock while no result stalls; the lexer mode register closes
// the per-character loop. A stalled result holds the step, and stage 1 still takes one
// more input transaction before the input stalls.
// Reset clears both stage valids, sets the mode to blank and clears the line error.
// A result is presented on the master side until it is taken.
module quoted_token_lexer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] ch
	input  logic                         s_tlast,  // line_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,  // [7:0] out_char
	output logic [qtl_pkg::UserW-1:0]    m_tuser,  // has_char, token_end, token_discard, line_ok
	output logic                         m_tlast   // line_done
);

	logic             valid_s1, valid_s2;
	logic [7:0]       ch_s1;
	logic             eol_s1;
	qtl_pkg::result_t res_step, res_s2;
	logic             adv_s2, step_en;

	// Move stage 1 on whenever the result register is free or being drained
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign step_en  = valid_s1 && adv_s2;

	qtl_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.ch       (ch_s1),
		.line_end (eol_s1),
		.res      (res_step)
	);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Capture input transaction and lexer result
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1  <= s_tdata;
			eol_s1 <= s_tlast;
		end
		if (step_en)
			res_s2 <= res_step;
	end

	// Drive the result channel
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.out_char;
	assign m_tlast  = res_s2.line_done;
	always_comb begin
		m_tuser                       = '0;
		m_tuser[qtl_pkg::UserHasChar] = res_s2.has_char;
		m_tuser[qtl_pkg::UserTokEnd]  = res_s2.token_end;
		m_tuser[qtl_pkg::UserTokDisc] = res_s2.token_discard;
		m_tuser[qtl_pkg::UserLineOk]  = res_s2.line_ok;
	end

endmodule

// ----- rtl/qtl_checker.sv -----
// Port-level checks for the quoted token lexer, bound to the top level.
module qtl_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [7:0]                m_tdata,
	input logic [qtl_pkg::UserW-1:0] m_tuser,
	input logic                      m_tlast
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Drive zero on the character when no character is carried
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[qtl_pkg::UserHasChar] |-> m_tdata == 8'h00)
		else $error("character without has_char");

	// Report line status only at a terminator
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[qtl_pkg::UserLineOk] |-> m_tlast)
		else $error("line_ok outside line end");

	// Keep character, token end and discard mutually exclusive
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tuser[qtl_pkg::UserTokDisc:qtl_pkg::UserHasChar]) <= 1)
		else $error("conflicting token flags");

endmodule

bind quoted_token_lexer_unit qtl_checker u_qtl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
